/* rtl/core/kmcs_pkg.sv */
// Shared types, codes and constants of the kinetic Monte Carlo event table.
`timescale 1ns / 1ps

package kmcs_pkg;

  // Default table depth.
  localparam int unsigned DEPTH_DEF = 1024;

  // Number of values per class index and width of the running rate total.
  localparam int unsigned NCLASS  = 5;
  localparam int unsigned RATE_TW = 42;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_RMI = 2'd1,
    FN_RNB = 2'd2,
    FN_SEL = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // One stored event, 64 bits.
  typedef struct packed {
    logic [1:0]  atype;
    logic [5:0]  fr;
    logic [5:0]  fc;
    logic [5:0]  tr;
    logic [5:0]  tc;
    logic [2:0]  ci;
    logic [2:0]  cj;
    logic [31:0] rate;
  } entry_t;

  // Request to step one class counter up or down.
  typedef struct packed {
    logic       en;
    logic       up;
    logic [2:0] ci;
    logic [2:0] cj;
  } tally_req_t;

endpackage

/* rtl/core/kmcs_tally.sv */
// Per-class event counters with one step port and one read port.
`timescale 1ns / 1ps

module kmcs_tally import kmcs_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tally_req_t                 req,
  input  logic [2:0]                 rd_ci,
  input  logic [2:0]                 rd_cj,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NC = NCLASS * NCLASS;
  localparam int unsigned IW = $clog2(NC);

  logic [CW-1:0] cnt [NC];
  logic          req_ok;
  logic [IW-1:0] req_idx;
  logic          rd_ok;
  logic [IW-1:0] rd_idx;

  // Only classes inside the five by five grid are counted.
  always_comb begin
    req_ok  = (req.ci < 3'(NCLASS)) && (req.cj < 3'(NCLASS));
    req_idx = IW'(req.ci) * IW'(NCLASS) + IW'(req.cj);
    rd_ok   = (rd_ci < 3'(NCLASS)) && (rd_cj < 3'(NCLASS));
    rd_idx  = IW'(rd_ci) * IW'(NCLASS) + IW'(rd_cj);
    count   = rd_ok ? cnt[rd_idx] : '0;
  end

  // Counter update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NC; k++) cnt[k] <= '0;
    end else if (req.en && req_ok) begin
      if (req.up) cnt[req_idx] <= cnt[req_idx] + CW'(1);
      else        cnt[req_idx] <= cnt[req_idx] - CW'(1);
    end
  end

endmodule

/* rtl/core/kmc_event_table_select.sv */
// Event table of a kinetic Monte Carlo engine: add, remove and rate-weighted select.
`timescale 1ns / 1ps

// Channel  Dir  tuser        tdata
// s_axis   in   func [1:0]   event fields, index, radius, random value (112 bits)
// m_axis   out  -            status, chosen event, counts, rate sum (112 bits)
//
// One result per item. Add writes the entry; remove by index moves the last live
// entry into the freed slot unless it was the last. Select forms the threshold
// in two partial products, then scans from slot 0 until the weighted sum passes
// it or the last entry is read; the event memory read port delivers one entry per
// cycle. Neighborhood remove examines slots in order and refills a deleted slot
// with the last live entry. Reset (rst, synchronous) clears the counts and rate
// total; memory needs no clearing. A held result stalls the next item only in S_FIN.

module kmc_event_table_select import kmcs_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // atom_type, from_row, from_col, to_row, to_col, class_i, class_j,
  // rate_value, entry_index, radius, random_fraction, zero fill
  input  logic [111:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, chosen_type, chosen_from_row, chosen_from_col, chosen_to_row,
  // chosen_to_col, chosen_class_i, chosen_class_j, removed_count,
  // live_entries, sum_of_rates, class_tally_out, zero fill
  output logic [111:0] m_tdata
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IXW  = (CW > 10) ? CW : 10;
  localparam int unsigned PW   = 73;
  localparam int unsigned CMPW = (63 + CW > PW) ? 63 + CW : PW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL0  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_RI_A  = 9'b000010000,
    S_RI_B  = 9'b000100000,
    S_NB_RD = 9'b001000000,
    S_NB_EV = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t               state;
  logic [CW-1:0]        live_count;
  logic [RATE_TW-1:0]   rate_total;
  logic [5:0]           fr_q, fc_q;
  logic [2:0]           ci_q, cj_q, rad_q;
  logic [IXW-1:0]       idx_q;
  logic [30:0]          rnd_q;
  logic [PW-1:0]        prod;
  logic [CMPW-1:0]      acc;
  entry_t               pick;
  status_t              status_q;
  logic [CW-1:0]        removed_q;
  logic [CW-1:0]        pos;
  logic                 pend_move;

  entry_t               mem [DEPTH];
  entry_t               rdata;
  logic                 rd_en, we;
  logic [AW-1:0]        raddr, waddr;
  entry_t               wdata;

  logic                 accept;
  func_t                func_in;
  entry_t               ent_in;
  logic [IXW-1:0]       idx_in;
  tally_req_t           treq;
  logic [CW-1:0]        tally_cnt;
  logic [CW-1:0]        le;
  logic                 nb_match;
  logic [5:0]           dr, dc;
  logic [62:0]          scaled;
  logic [CMPW-1:0]      acc_new;
  logic                 hit, last;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign func_in  = func_t'(s_tuser);

  // Unpack the input item.
  always_comb begin
    ent_in.atype = s_tdata[1:0];
    ent_in.fr    = s_tdata[7:2];
    ent_in.fc    = s_tdata[13:8];
    ent_in.tr    = s_tdata[19:14];
    ent_in.tc    = s_tdata[25:20];
    ent_in.ci    = s_tdata[28:26];
    ent_in.cj    = s_tdata[31:29];
    ent_in.rate  = s_tdata[63:32];
    idx_in       = IXW'(s_tdata[73:64]);
  end

  // Neighborhood test and running weighted sum on the entry just read.
  always_comb begin
    le       = pend_move ? live_count - CW'(1) : live_count;
    dr       = (rdata.fr > fr_q) ? rdata.fr - fr_q : fr_q - rdata.fr;
    dc       = (rdata.fc > fc_q) ? rdata.fc - fc_q : fc_q - rdata.fc;
    nb_match = (dr <= 6'(rad_q)) && (dc <= 6'(rad_q));
    scaled   = {rdata.rate, 31'b0} - 63'(rdata.rate);
    acc_new  = acc + CMPW'(scaled);
    hit      = acc_new > CMPW'(prod);
    last     = (pos == live_count - CW'(1));
  end

  // Memory port and class counter control.
  always_comb begin
    rd_en   = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = ent_in;
    treq    = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && func_in == FN_ADD && live_count < CW'(DEPTH)) begin
          we      = 1'b1;
          waddr   = live_count[AW-1:0];
          treq.en = 1'b1;
          treq.up = 1'b1;
          treq.ci = ent_in.ci;
          treq.cj = ent_in.cj;
        end
        if (accept && func_in == FN_RMI && idx_in < IXW'(live_count)) begin
          rd_en = 1'b1;
          raddr = idx_in[AW-1:0];
        end
      end
      S_MUL0: ;
      S_MUL1: begin
        rd_en = 1'b1;
      end
      S_SCAN: begin
        if (!(hit || last)) begin
          rd_en = 1'b1;
          raddr = pos[AW-1:0] + AW'(1);
        end
      end
      S_RI_A: begin
        treq.en = 1'b1;
        treq.ci = rdata.ci;
        treq.cj = rdata.cj;
        if (idx_q != IXW'(live_count - CW'(1))) begin
          rd_en = 1'b1;
          raddr = live_count[AW-1:0] - AW'(1);
        end
      end
      S_RI_B: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        wdata = rdata;
      end
      S_NB_RD: begin
        if (pos < live_count) begin
          rd_en = 1'b1;
          raddr = pos[AW-1:0];
        end
      end
      S_NB_EV: begin
        if (pend_move) begin
          we    = 1'b1;
          waddr = pos[AW-1:0];
          wdata = rdata;
        end
        if (nb_match) begin
          treq.en = 1'b1;
          treq.ci = rdata.ci;
          treq.cj = rdata.cj;
          if (pos != le - CW'(1)) begin
            rd_en = 1'b1;
            raddr = le[AW-1:0] - AW'(1);
          end
        end
      end
      S_FIN: ;
      default: ;
    endcase
  end

  // Event memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  kmcs_tally #(
    .DEPTH (DEPTH)
  ) u_tally (
    .clk   (clk),
    .rst   (rst),
    .req   (treq),
    .rd_ci (ci_q),
    .rd_cj (cj_q),
    .count (tally_cnt)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      rate_total <= '0;
      m_tvalid   <= 1'b0;
      pend_move  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fr_q      <= ent_in.fr;
            fc_q      <= ent_in.fc;
            ci_q      <= ent_in.ci;
            cj_q      <= ent_in.cj;
            rad_q     <= s_tdata[76:74];
            idx_q     <= idx_in;
            rnd_q     <= s_tdata[107:77];
            pick      <= '0;
            status_q  <= ST_OK;
            removed_q <= '0;
            pos       <= '0;
            pend_move <= 1'b0;
            acc       <= '0;
            unique case (func_in)
              FN_ADD: begin
                if (live_count >= CW'(DEPTH)) begin
                  status_q <= ST_FULL;
                end else begin
                  live_count <= live_count + CW'(1);
                  rate_total <= rate_total + RATE_TW'(ent_in.rate);
                end
                state <= S_FIN;
              end
              FN_RMI: begin
                if (idx_in >= IXW'(live_count)) begin
                  status_q <= ST_BAD;
                  state    <= S_FIN;
                end else begin
                  state <= S_RI_A;
                end
              end
              FN_RNB: state <= S_NB_RD;
              FN_SEL: begin
                if (live_count == '0) begin
                  status_q <= ST_BAD;
                  state    <= S_FIN;
                end else begin
                  state <= S_MUL0;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        // Threshold r*T in two partial products.
        S_MUL0: begin
          prod  <= PW'(63'(rnd_q) * 63'(rate_total[31:0]));
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= prod + (PW'(41'(rnd_q) * 41'(rate_total[RATE_TW-1:32])) << 32);
          state <= S_SCAN;
        end
        S_SCAN: begin
          acc  <= acc_new;
          pick <= rdata;
          if (hit || last) state <= S_FIN;
          else pos <= pos + CW'(1);
        end
        S_RI_A: begin
          rate_total <= rate_total - RATE_TW'(rdata.rate);
          removed_q  <= CW'(1);
          if (idx_q == IXW'(live_count - CW'(1))) begin
            live_count <= live_count - CW'(1);
            state      <= S_FIN;
          end else begin
            state <= S_RI_B;
          end
        end
        S_RI_B: begin
          live_count <= live_count - CW'(1);
          state      <= S_FIN;
        end
        S_NB_RD: begin
          if (pos >= live_count) state <= S_FIN;
          else state <= S_NB_EV;
        end
        // Examine slot pos; a refilled slot is examined again here.
        S_NB_EV: begin
          pend_move <= 1'b0;
          if (nb_match) begin
            rate_total <= rate_total - RATE_TW'(rdata.rate);
            removed_q  <= removed_q + CW'(1);
            if (pos == le - CW'(1)) begin
              live_count <= le - CW'(1);
              state      <= S_NB_RD;
            end else begin
              live_count <= le;
              pend_move  <= 1'b1;
            end
          end else begin
            live_count <= le;
            pos        <= pos + CW'(1);
            state      <= S_NB_RD;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid        <= 1'b1;
            m_tdata[1:0]    <= status_q;
            m_tdata[3:2]    <= pick.atype;
            m_tdata[9:4]    <= pick.fr;
            m_tdata[15:10]  <= pick.fc;
            m_tdata[21:16]  <= pick.tr;
            m_tdata[27:22]  <= pick.tc;
            m_tdata[30:28]  <= pick.ci;
            m_tdata[33:31]  <= pick.cj;
            m_tdata[44:34]  <= 11'(removed_q);
            m_tdata[55:45]  <= 11'(live_count);
            m_tdata[97:56]  <= rate_total;
            m_tdata[108:98] <= 11'(tally_cnt);
            m_tdata[111:109] <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
